[sv/xxrf_pkg.sv]
// ----------------------------------------------------------------------------
// xxrf_pkg
// Shared codes and constants of the XON/XOFF receive FIFO.
// ----------------------------------------------------------------------------
package xxrf_pkg;

    // Flow control characters sent toward the remote sender
    localparam logic [7:0] XON_CHAR  = 8'h11;
    localparam logic [7:0] XOFF_CHAR = 8'h13;

    // Configuration register indexes
    localparam logic [7:0] CFG_HIGH_LIMIT = 8'd0;
    localparam logic [7:0] CFG_LOW_LIMIT  = 8'd1;

    // Reset values of the limits
    localparam logic [7:0] HIGH_LIMIT_RESET = 8'd64;
    localparam logic [7:0] LOW_LIMIT_RESET  = 8'd8;

    // Input operation carried in tuser
    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // Result kind carried in tuser
    typedef enum logic [1:0]
    {
        KIND_FLOW = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_DROP = 2'd2
    } kind_t;

endpackage

[sv/xon_xoff_receive_fifo.sv]
// ----------------------------------------------------------------------------
// xon_xoff_receive_fifo
// Receive byte FIFO with XON/XOFF hysteresis flow control toward the sender.
// ----------------------------------------------------------------------------
// A push item (tuser = 0) stores the byte in tdata. When the count after the
// push exceeds high_limit while flow is on, one result goes out: XOFF (0x13)
// with kind 0, and flow turns off. A push into a full store keeps nothing and
// returns the byte with kind 2. A pop item (tuser = 1) removes the oldest
// byte and returns it with kind 1; when the count left is below low_limit
// while flow is off, an XON (0x11) with kind 0 and tlast low goes out first,
// and flow turns on. A pop of an empty store and a push without a flow change
// return nothing. The store is a single-port write, single-port
// registered-read memory, and the pointers, count, flow state and result
// stage update at the accepting edge, so a new item can be taken every cycle
// as long as results are drained. A pop that sends XON holds two output
// beats; the input waits for the second to leave. The limit registers reset
// to 64 and 8 and are written through the cfg channel; the user must write
// them only while the block is idle; the block does not enforce it. Writes
// to other indexes are ignored. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module xon_xoff_receive_fifo #(
    parameter int DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,

    // Input items
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tuser,   // [0] op

    // Result items
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] value
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast,

    // Configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    import xxrf_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW + 1 : 9;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // Byte store, written and read in clocked blocks
    logic [7:0]    mem_reg [DEPTH];
    logic [7:0]    rd_data_reg;

    // Pointers, count and flow state
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          flow_on_reg, flow_on_next;

    // Limits
    logic [7:0]    high_limit_reg;
    logic [7:0]    low_limit_reg;

    // Output stage
    logic          out_valid_reg, out_valid_next;
    logic          xon_pending_reg, xon_pending_next;
    logic          from_mem_reg, from_mem_next;
    kind_t         out_kind_reg, out_kind_next;
    logic [7:0]    out_value_reg, out_value_next;

    logic          in_fire;
    logic          out_fire;
    logic          do_push;
    logic          do_pop;
    logic          is_full;
    logic          is_empty;
    logic [CMPW-1:0] count_up;
    logic [CMPW-1:0] count_down;

    assign cfg_ready = 1'b1;

    // Take a new item when the stage is empty or its final beat leaves now
    assign s_axis_tready = !out_valid_reg || (m_axis_tready && !xon_pending_reg);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign do_push  = in_fire && (op_t'(s_axis_tuser) == OP_PUSH) && !is_full;
    assign do_pop   = in_fire && (op_t'(s_axis_tuser) == OP_POP) && !is_empty;

    // Count after the operation, wide enough to compare with the limits
    assign count_up   = CMPW'(count_reg) + CMPW'(1);
    assign count_down = CMPW'(count_reg) - CMPW'(1);

    always_comb
    begin
        wptr_next        = wptr_reg;
        rptr_next        = rptr_reg;
        count_next       = count_reg;
        flow_on_next     = flow_on_reg;
        out_valid_next   = out_valid_reg;
        xon_pending_next = xon_pending_reg;
        from_mem_next    = from_mem_reg;
        out_kind_next    = out_kind_reg;
        out_value_next   = out_value_reg;

        // Advance the output stage
        if (out_fire)
        begin
            if (xon_pending_reg)
            begin
                xon_pending_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (in_fire)
        begin
            if (op_t'(s_axis_tuser) == OP_PUSH)
            begin
                if (is_full)
                begin
                    // Drop the byte and report it
                    out_valid_next   = 1'b1;
                    xon_pending_next = 1'b0;
                    from_mem_next    = 1'b0;
                    out_kind_next    = KIND_DROP;
                    out_value_next   = s_axis_tdata;
                end
                else
                begin
                    wptr_next  = (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + AW'(1);
                    count_next = count_reg + CW'(1);
                    if (flow_on_reg && (count_up > CMPW'(high_limit_reg)))
                    begin
                        flow_on_next     = 1'b0;
                        out_valid_next   = 1'b1;
                        xon_pending_next = 1'b0;
                        from_mem_next    = 1'b0;
                        out_kind_next    = KIND_FLOW;
                        out_value_next   = XOFF_CHAR;
                    end
                end
            end
            else if (!is_empty)
            begin
                rptr_next        = (rptr_reg == LAST_ADDR) ? '0 : rptr_reg + AW'(1);
                count_next       = count_reg - CW'(1);
                out_valid_next   = 1'b1;
                from_mem_next    = 1'b1;
                out_kind_next    = KIND_BYTE;
                xon_pending_next = 1'b0;
                if (!flow_on_reg && (count_down < CMPW'(low_limit_reg)))
                begin
                    // Send XON ahead of the byte
                    flow_on_next     = 1'b1;
                    xon_pending_next = 1'b1;
                end
            end
        end
    end

    // Drive the result beat
    always_comb
    begin
        m_axis_tvalid = out_valid_reg;
        if (xon_pending_reg)
        begin
            m_axis_tuser = KIND_FLOW;
            m_axis_tdata = XON_CHAR;
            m_axis_tlast = 1'b0;
        end
        else
        begin
            m_axis_tuser = out_kind_reg;
            m_axis_tdata = from_mem_reg ? rd_data_reg : out_value_reg;
            m_axis_tlast = 1'b1;
        end
    end

    // Store write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= s_axis_tdata;
        end
    end

    // Store read, held until the next pop
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            rd_data_reg <= mem_reg[rptr_reg];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg        <= '0;
            rptr_reg        <= '0;
            count_reg       <= '0;
            flow_on_reg     <= 1'b1;
            out_valid_reg   <= 1'b0;
            xon_pending_reg <= 1'b0;
            from_mem_reg    <= 1'b0;
            out_kind_reg    <= KIND_FLOW;
        end
        else
        begin
            wptr_reg        <= wptr_next;
            rptr_reg        <= rptr_next;
            count_reg       <= count_next;
            flow_on_reg     <= flow_on_next;
            out_valid_reg   <= out_valid_next;
            xon_pending_reg <= xon_pending_next;
            from_mem_reg    <= from_mem_next;
            out_kind_reg    <= out_kind_next;
        end
    end

    // Payload of the output stage
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_limit_reg <= HIGH_LIMIT_RESET;
            low_limit_reg  <= LOW_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                CFG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

endmodule

[test/tb_xon_xoff_receive_fifo.sv]
// ----------------------------------------------------------------------------
// tb_xon_xoff_receive_fifo
// Self-checking bench for the XON/XOFF receive FIFO.
// ----------------------------------------------------------------------------
// A short table of directed items and limit writes runs first. It covers a pop
// of an empty store, the extreme bytes, the XOFF and XON paths and limit
// writes to unknown indexes. Next the store is filled past full while the
// result side holds off, then drained. Random phases under several limit
// settings follow. Every accepted item runs through a local model of the
// store and flow state. Each result is compared field by field against the
// oldest expectation.
// ----------------------------------------------------------------------------
module tb_xon_xoff_receive_fifo;

    import xxrf_pkg::*;

    localparam int DEPTH = 256;

    // One result as it leaves the block
    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } flow_result_t;

    // Results that one input item causes; typed marks a row whose results
    // are written out in the table rather than taken from the model
    typedef struct packed
    {
        logic         typed;
        logic [1:0]   count;
        flow_result_t first;
        flow_result_t second;
    } item_note_t;

    typedef enum logic
    {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t  kind;
        logic [7:0] index;
        logic [7:0] data;
        op_t        op;
        item_note_t note;
    } stim_row_t;

    localparam flow_result_t NO_RES = '0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic       s_axis_tuser = 1'b0;    // [0] op

    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] value
    logic [1:0] m_axis_tuser;           // [1:0] kind
    logic       m_axis_tlast;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data = 8'h00;

    // Local copy of the block state
    logic [7:0]   held_bytes[$];
    logic         sender_on = 1'b1;
    logic [7:0]   high_limit = HIGH_LIMIT_RESET;
    logic [7:0]   low_limit = LOW_LIMIT_RESET;

    flow_result_t pending_results[$];   // results still owed by the block
    item_note_t   offered_items[$];     // one note per item offered, in order
    stim_row_t    directed_rows[$];

    int fail_count = 0;
    int rx_hold_cycles = 0;             // long hold-off requested of the receiver
    int rx_gap = 0;
    int rx_calm = 0;
    int tx_calm = 0;

    xon_xoff_receive_fifo #(
        .DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic flow_result_t res(kind_t k, logic [7:0] v, logic l);
        flow_result_t r;
        r.kind  = k;
        r.value = v;
        r.last  = l;
        return r;
    endfunction

    // Advance the local state by one item and return the results it causes.
    // Push: store the byte, or drop it when full; XOFF once the count rises
    // past high_limit while the sender is on.
    // Pop: hand out the oldest byte, preceded by XON once the count falls
    // below low_limit while the sender is off.
    function automatic item_note_t flow_response(op_t op, logic [7:0] b);
        item_note_t note;
        logic [7:0] head;
        note = '0;
        if (op == OP_PUSH)
        begin
            if (held_bytes.size() >= DEPTH)
            begin
                note.count = 2'd1;
                note.first = res(KIND_DROP, b, 1'b1);
            end
            else
            begin
                held_bytes.push_back(b);
                if (held_bytes.size() > int'(high_limit) && sender_on)
                begin
                    sender_on  = 1'b0;
                    note.count = 2'd1;
                    note.first = res(KIND_FLOW, XOFF_CHAR, 1'b1);
                end
            end
        end
        else if (held_bytes.size() != 0)
        begin
            head = held_bytes.pop_front();
            if (held_bytes.size() < int'(low_limit) && !sender_on)
            begin
                sender_on   = 1'b1;
                note.count  = 2'd2;
                note.first  = res(KIND_FLOW, XON_CHAR, 1'b0);
                note.second = res(KIND_BYTE, head, 1'b1);
            end
            else
            begin
                note.count = 2'd1;
                note.first = res(KIND_BYTE, head, 1'b1);
            end
        end
        return note;
    endfunction

    function automatic void add_cfg(logic [7:0] index, logic [7:0] data);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.index = index;
        row.data  = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(op_t op, logic [7:0] b, logic typed,
                                     logic [1:0] n, flow_result_t r0,
                                     flow_result_t r1);
        stim_row_t row;
        row             = '0;
        row.kind        = ROW_ITEM;
        row.op          = op;
        row.data        = b;
        row.note.typed  = typed;
        row.note.count  = n;
        row.note.first  = r0;
        row.note.second = r1;
        directed_rows.push_back(row);
    endfunction

    // Draw an idle gap: mostly none, some short, a few long, and now and
    // then a calm stretch with no gaps at all.
    task automatic draw_gap(inout int calm, output int len);
        int r;
        r   = $urandom_range(0, 99);
        len = 0;
        if (calm > 0)
            calm--;
        else if (r < 3)
            calm = $urandom_range(20, 80);
        else if (r < 25)
            len = $urandom_range(1, 3);
        else if (r < 28)
            len = $urandom_range(8, 40);
    endtask

    // Offer one item, hold it until taken, then maybe idle. While idle,
    // scramble the data lines; the block must ignore them.
    task automatic send_item(op_t op, logic [7:0] b, item_note_t note);
        int len;
        offered_items.push_back(note);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        draw_gap(tx_calm, len);
        if (len > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat (len) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every owed result has left, then give
    // items that cause no result time to settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 || offered_items.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] index, logic [7:0] data);
        drain_results();
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // Random items steered so that the count swings between the limits:
    // fill toward just above high_limit, then drain toward just below
    // low_limit or to empty. A few items go in the other direction.
    task automatic run_random_phase(logic [7:0] hi, logic [7:0] lo, int n_items);
        int  occ;
        int  target;
        int  r;
        bit  filling;
        op_t op;
        write_reg(CFG_HIGH_LIMIT, hi);
        write_reg(CFG_LOW_LIMIT, lo);
        filling = 1'b1;
        target  = int'(hi) + 1 + $urandom_range(0, 4);
        for (int i = 0; i < n_items; i++)
        begin
            occ = held_bytes.size();
            if (filling && occ >= target)
            begin
                filling = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    target = 0;
                else
                    target = int'(lo) - 1 - $urandom_range(0, 3);
            end
            else if (!filling && occ <= target)
            begin
                filling = 1'b1;
                target  = int'(hi) + 1 + $urandom_range(0, 4);
                if (target > DEPTH)
                    target = DEPTH;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                op = op_t'($urandom_range(0, 1));
            else if (filling)
                op = (r < 85) ? OP_PUSH : OP_POP;
            else
                op = (r < 15) ? OP_PUSH : OP_POP;
            // Pause the sender once mid-phase until everything is out
            if (i == n_items / 2)
                drain_results();
            send_item(op, 8'($urandom_range(0, 255)), '0);
        end
    endtask

    // Receiver: random ready, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        int len;
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            draw_gap(rx_calm, len);
            if (len == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                rx_gap = len - 1;
            end
        end
    end

    // Monitor: limit writes and accepted items update the local state first,
    // then an accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        item_note_t   got;
        item_note_t   note;
        flow_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                case (cfg_index)
                    CFG_HIGH_LIMIT: high_limit = cfg_data;
                    CFG_LOW_LIMIT:  low_limit  = cfg_data;
                    default:        ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready === 1'b1)
            begin
                got = flow_response(op_t'(s_axis_tuser), s_axis_tdata);
                if (offered_items.size() != 0)
                begin
                    note = offered_items.pop_front();
                    // Table rows with written-out results take precedence
                    if (note.typed)
                        got = note;
                end
                if (got.count >= 2'd1)
                    pending_results.push_back(got.first);
                if (got.count == 2'd2)
                    pending_results.push_back(got.second);
            end

            if (m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected, kind %0d value %02h last %0b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.kind)
                    begin
                        $display("%0t: kind mismatch, expected %0d, actual %0d",
                                 $time, want.kind, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %02h, actual %02h",
                                 $time, want.value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;

        // Reset limits 64 / 8: pop of empty, extreme byte in and out
        add_item(OP_POP,  8'hC3, 1'b1, 2'd0, NO_RES, NO_RES);
        add_item(OP_PUSH, 8'hFF, 1'b1, 2'd0, NO_RES, NO_RES);
        add_item(OP_POP,  8'h3C, 1'b1, 2'd1, res(KIND_BYTE, 8'hFF, 1'b1), NO_RES);

        // Limits 0 / 255: XOFF on the first push, XON on the next pop
        add_cfg(CFG_HIGH_LIMIT, 8'd0);
        add_cfg(CFG_LOW_LIMIT, 8'd255);
        add_item(OP_PUSH, 8'h00, 1'b1, 2'd1, res(KIND_FLOW, XOFF_CHAR, 1'b1), NO_RES);
        add_item(OP_PUSH, 8'hFF, 1'b1, 2'd0, NO_RES, NO_RES);
        add_item(OP_PUSH, 8'hA5, 1'b0, 2'd0, NO_RES, NO_RES);
        add_item(OP_POP,  8'hFF, 1'b1, 2'd2, res(KIND_FLOW, XON_CHAR, 1'b0),
                 res(KIND_BYTE, 8'h00, 1'b1));
        add_item(OP_POP,  8'h00, 1'b1, 2'd1, res(KIND_BYTE, 8'hFF, 1'b1), NO_RES);
        add_item(OP_PUSH, 8'h5A, 1'b1, 2'd1, res(KIND_FLOW, XOFF_CHAR, 1'b1), NO_RES);
        add_item(OP_POP,  8'h5A, 1'b0, 2'd0, NO_RES, NO_RES);
        add_item(OP_POP,  8'hA5, 1'b1, 2'd1, res(KIND_BYTE, 8'h5A, 1'b1), NO_RES);
        add_item(OP_POP,  8'h00, 1'b1, 2'd0, NO_RES, NO_RES);

        // Limits 255 / 0: no flow characters for a small count
        add_cfg(CFG_HIGH_LIMIT, 8'd255);
        add_cfg(CFG_LOW_LIMIT, 8'd0);
        add_item(OP_PUSH, 8'h01, 1'b0, 2'd0, NO_RES, NO_RES);
        add_item(OP_POP,  8'hFE, 1'b1, 2'd1, res(KIND_BYTE, 8'h01, 1'b1), NO_RES);

        // Unknown indexes: had either landed on high_limit, the push would
        // send XOFF
        add_cfg(8'd2, 8'd0);
        add_cfg(8'd255, 8'd0);
        add_item(OP_PUSH, 8'h02, 1'b1, 2'd0, NO_RES, NO_RES);
        add_item(OP_POP,  8'h00, 1'b1, 2'd1, res(KIND_BYTE, 8'h02, 1'b1), NO_RES);

        // Limits 1 / 1: XOFF at count 2, XON back at count 0
        add_cfg(CFG_HIGH_LIMIT, 8'd1);
        add_cfg(CFG_LOW_LIMIT, 8'd1);
        add_item(OP_PUSH, 8'h80, 1'b1, 2'd0, NO_RES, NO_RES);
        add_item(OP_PUSH, 8'h7F, 1'b1, 2'd1, res(KIND_FLOW, XOFF_CHAR, 1'b1), NO_RES);
        add_item(OP_POP,  8'h55, 1'b1, 2'd1, res(KIND_BYTE, 8'h80, 1'b1), NO_RES);
        add_item(OP_POP,  8'hAA, 1'b1, 2'd2, res(KIND_FLOW, XON_CHAR, 1'b0),
                 res(KIND_BYTE, 8'h7F, 1'b1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_reg(row.index, row.data);
            else
                send_item(row.op, row.data, row.note);
        end

        // Fill past full while the receiver holds off: XOFF comes at the
        // last free entry, the extra pushes are dropped, and pending results
        // stall the input. Then drain to empty with XON on the way down.
        write_reg(CFG_HIGH_LIMIT, 8'd255);
        write_reg(CFG_LOW_LIMIT, 8'd200);
        rx_hold_cycles = 1500;
        repeat (DEPTH + 3) send_item(OP_PUSH, 8'($urandom_range(0, 255)), '0);
        repeat (DEPTH + 1) send_item(OP_POP, 8'($urandom_range(0, 255)), '0);

        run_random_phase(HIGH_LIMIT_RESET, LOW_LIMIT_RESET, 100);
        run_random_phase(8'd0, 8'd0, 100);
        run_random_phase(8'd255, 8'd255, 100);
        run_random_phase(8'd12, 8'd4, 100);
        run_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 100);

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
sv/xxrf_pkg.sv
sv/xon_xoff_receive_fifo.sv
test/tb_xon_xoff_receive_fifo.sv
